>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the capture meter RTL files.
// Depends on nothing; included by each file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons on the next cycle");

`endif

>>> hw/rtl/cprm_pkg.sv
// Shared constants and types of the capture pulse reciprocal meter.
// Depends on nothing; used by the interfaces, the divider and the top level.
package cprm_pkg;

   // Field widths of the beats and of the clock register.
   localparam int FUNC_W = 2;
   localparam int CAP_W  = 16;
   localparam int CLK_W  = 27;

   // Capture counter and overflow tally sizes.
   localparam int COUNTER_BITS  = 16;
   localparam int OVERFLOW_BITS = 5;

   // Raw pulse time, divisor (raw plus one) and dividend (ten times the clock).
   localparam int RAW_W = COUNTER_BITS + OVERFLOW_BITS;
   localparam int DVS_W = RAW_W + 1;
   localparam int DVD_W = CLK_W + 4;

   // Rounding stage: floor(x / 10) = (x * RND_MAGIC) >> RND_SHIFT for 32-bit x.
   localparam int          RND_W     = 32;
   localparam logic [31:0] RND_MAGIC = 32'hCCCC_CCCD;
   localparam int          RND_SHIFT = 35;

   localparam logic [CLK_W-1:0] CLK_RESET_HZ = CLK_W'(1000 * 1000);

   // Event kinds carried in func; the unused code decodes like FUNC_BOTH.
   localparam logic [FUNC_W-1:0] FUNC_OVERFLOW = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EDGE     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BOTH     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCALE,
      ST_FINISH
   } cprm_state_type;

endpackage

>>> hw/rtl/cprm_if.sv
// Valid/ready channels of the capture meter: event beats in, result beats out.
// Depends on cprm_pkg for the field widths.
interface cprm_req_if;
   logic                          valid;
   logic                          ready;
   logic [cprm_pkg::FUNC_W-1:0]   func;
   logic [cprm_pkg::CAP_W-1:0]    captured_count;

   modport source (output valid, func, captured_count, input ready);
   modport sink   (input valid, func, captured_count, output ready);
endinterface

interface cprm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          measure_done;
   logic [cprm_pkg::CLK_W-1:0]    frequency_value;
   logic                          overflow_abort;
   logic                          armed;

   modport source (output valid, measure_done, frequency_value, overflow_abort, armed,
                   input ready);
   modport sink   (input valid, measure_done, frequency_value, overflow_abort, armed,
                   output ready);
endinterface

>>> hw/rtl/cprm_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on cprm_pkg for the dividend and divisor widths.
`include "assert_macros.svh"

module cprm_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        div_start,
   input  logic [cprm_pkg::DVD_W-1:0]  dividend,
   input  logic [cprm_pkg::DVS_W-1:0]  divisor,
   output logic                        div_done,
   output logic [cprm_pkg::DVD_W-1:0]  quotient
);
   import cprm_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   // One trial subtraction: bring the next dividend bit into the remainder.
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

   // A new division is never started while one is running.
   `ASSERT_IMPLY(start_when_idle_a, clock, reset, div_start, !busy_ff)
   // The done pulse follows the last step and the unit is then free.
   `ASSERT_IMPLY(done_not_busy_a, clock, reset, done_ff, !busy_ff)
   // The done pulse lasts a single cycle.
   `ASSERT_NEXT(done_single_a, clock, reset, done_ff, !done_ff)

endmodule

>>> hw/rtl/capture_pulse_reciprocal_meter.sv
// Capture pulse reciprocal meter: an overflow or edge beat in, one result beat out.
// A beat that is not a stop edge loads the result register directly; a stop edge goes
// through 31 divider steps, its done pulse, a rounding multiply and the output load.
// Throughput: one beat per cycle while the output is free; none until a stop edge's result is loaded.
// Reset is synchronous, active high: clears tally and flags, clock register 1000000 Hz.
// Depends on cprm_pkg, cprm_if and cprm_divider.
`include "assert_macros.svh"

module capture_pulse_reciprocal_meter (
   input  logic                        clock,
   input  logic                        reset,
   cprm_req_if.sink                    req_if,
   cprm_rsp_if.source                  rsp_if,
   input  logic                        csr_write_enable,
   input  logic [cprm_pkg::CLK_W-1:0]  csr_write_data
);
   import cprm_pkg::*;

   cprm_state_type state_ff, state_in;

   logic [OVERFLOW_BITS-1:0] tally_ff, tally_in;
   logic                     start_ff, start_in;
   logic                     complete_ff, complete_in;
   logic [CLK_W-1:0]         clk_hz_ff, clk_hz_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic [CLK_W-1:0]         rsp_freq_ff, rsp_freq_in;
   logic                     rsp_abort_ff, rsp_abort_in;
   logic                     rsp_armed_ff, rsp_armed_in;
   logic [2*RND_W-1:0]       prod_ff, prod_in;

   logic                     accept, rsp_free, req_ready;
   logic                     ovf, edge_seen, count_ovf, abort_flag, start_mid, stop;
   logic [OVERFLOW_BITS-1:0] tally_step;
   logic [RAW_W-1:0]         raw;
   logic [DVS_W-1:0]         divisor;
   logic [DVD_W-1:0]         dividend;
   logic [DVD_W-1:0]         quotient;
   logic [RND_W-1:0]         rnd_sum;
   logic                     div_start, div_done;
   logic                     load_event, load_result;
   logic                     done_beat;

   // Handshake.
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = req_ready;
   assign accept       = req_if.valid && req_ready;

   // Event decode: overflow is counted first, then the edge is applied.
   assign ovf        = (req_if.func != FUNC_EDGE);
   assign edge_seen  = (req_if.func != FUNC_OVERFLOW);
   assign count_ovf  = ovf && !complete_ff;
   assign tally_step = count_ovf ? tally_ff + OVERFLOW_BITS'(1) : tally_ff;
   assign abort_flag = count_ovf && (tally_step == '0) && start_ff;
   assign start_mid  = start_ff && !abort_flag;
   assign stop       = edge_seen && start_mid;

   // Pulse time and the operands of the divider.
   assign raw      = {tally_step, COUNTER_BITS'(req_if.captured_count)};
   assign divisor  = DVS_W'(raw) + DVS_W'(1);
   assign dividend = (DVD_W'(clk_hz_ff) << 3) + (DVD_W'(clk_hz_ff) << 1);

   cprm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .div_done  (div_done),
      .quotient  (quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && stop) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_done) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready   = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = rsp_free;
         ST_FINISH: load_result = rsp_free;
         default:   req_ready = 1'b0;
      endcase
   end

   assign div_start  = accept && stop;
   assign load_event = accept && !stop;

   // Measurement state updated once per accepted beat.
   always_comb begin
      tally_in    = tally_ff;
      start_in    = start_ff;
      complete_in = complete_ff;
      if (accept) begin
         tally_in    = tally_step;
         start_in    = start_mid;
         complete_in = abort_flag ? 1'b0 : complete_ff;
         if (edge_seen) begin
            tally_in    = '0;
            start_in    = !start_mid;
            complete_in = start_mid;
         end
      end
   end

   // Round half up: (q + 5) / 10 by a reciprocal multiply.
   assign rnd_sum   = RND_W'(quotient) + RND_W'(5);
   assign prod_in   = (state_ff == ST_SCALE) ?
                      (2*RND_W)'(rnd_sum) * (2*RND_W)'(RND_MAGIC) : prod_ff;
   assign clk_hz_in = csr_write_enable ? csr_write_data : clk_hz_ff;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_done_in  = rsp_done_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_abort_in = rsp_abort_ff;
      rsp_armed_in = rsp_armed_ff;
      if (load_event) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = 1'b0;
         rsp_freq_in  = '0;
         rsp_abort_in = abort_flag;
         rsp_armed_in = start_in;
      end else if (load_result) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = 1'b1;
         rsp_freq_in  = prod_ff[RND_SHIFT +: CLK_W];
         rsp_abort_in = 1'b0;
         rsp_armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tally_ff     <= '0;
         start_ff     <= 1'b0;
         complete_ff  <= 1'b0;
         clk_hz_ff    <= CLK_RESET_HZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tally_ff     <= tally_in;
         start_ff     <= start_in;
         complete_ff  <= complete_in;
         clk_hz_ff    <= clk_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_done_ff  <= rsp_done_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_abort_ff <= rsp_abort_in;
      rsp_armed_ff <= rsp_armed_in;
      prod_ff      <= prod_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.measure_done    = rsp_done_ff;
   assign rsp_if.frequency_value = rsp_freq_ff;
   assign rsp_if.overflow_abort  = rsp_abort_ff;
   assign rsp_if.armed           = rsp_armed_ff;

   assign done_beat = rsp_valid_ff && rsp_done_ff;

   // A completed measurement disarms and is never an abort.
   `ASSERT_IMPLY(done_disarms_a, clock, reset, done_beat, !rsp_armed_ff && !rsp_abort_ff)
   // The divider only finishes while the sequencer waits for it.
   `ASSERT_IMPLY(div_done_state_a, clock, reset, div_done, state_ff == ST_DIVIDE)
   // A stop edge always hands the work to the divider.
   `ASSERT_NEXT(stop_divides_a, clock, reset, div_start, state_ff == ST_DIVIDE && !start_ff)

endmodule
